// ===== design/mnt_pkg.sv =====
package mnt_pkg;

  // Table geometry
  localparam int TABLE_SIZE = 64;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 48;
  localparam int LAYER_W  = 6;
  localparam int RIDX_W   = 6;
  localparam int STATUS_W = 4;
  localparam int ECNT_W   = 7;
  localparam int CMP_W    = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  // Largest count the result word can carry
  localparam int COUNT_MAX = (1 << ECNT_W) - 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_UPDATE = 2'd0,
    FN_REMOVE = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 4'd0,
    ST_UPDATED   = 4'd1,
    ST_UNCHANGED = 4'd2,
    ST_FULL      = 4'd3,
    ST_REMOVED   = 4'd4,
    ST_NOT_FOUND = 4'd5,
    ST_CLEARED   = 4'd6,
    ST_READ_OK   = 4'd7,
    ST_BAD_INDEX = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_WRITE,
    OP_APPEND,
    OP_SHIFT,
    OP_READ
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  key;
    logic [ADDR_W-1:0]  parent;
    logic [LAYER_W-1:0] layer;
  } cell_data_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ADDR_W-1:0]  key;
    logic [ADDR_W-1:0]  parent;
    logic [LAYER_W-1:0] layer;
    logic [CNT_W-1:0]   count;
    logic [RIDX_W-1:0]  read_index;
  } cell_cmd_t;

  typedef struct packed {
    logic       any_hit;
    logic       any_changed;
    cell_data_t rd;
  } row_stat_t;

endpackage

// ===== design/mnt_in_if.sv =====
interface mnt_in_if import mnt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ADDR_W-1:0]  node_addr;
  logic [ADDR_W-1:0]  parent_addr;
  logic [LAYER_W-1:0] layer;
  logic [RIDX_W-1:0]  read_index;

  modport source (
    output valid, func, node_addr, parent_addr, layer, read_index,
    input  ready
  );

  modport sink (
    input  valid, func, node_addr, parent_addr, layer, read_index,
    output ready
  );
endinterface

// ===== design/mnt_out_if.sv =====
interface mnt_out_if import mnt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ECNT_W-1:0]   entry_count;
  logic [ADDR_W-1:0]   out_node_addr;
  logic [ADDR_W-1:0]   out_parent_addr;
  logic [LAYER_W-1:0]  out_layer;

  modport source (
    output valid, status, entry_count, out_node_addr, out_parent_addr, out_layer,
    input  ready
  );

  modport sink (
    input  valid, status, entry_count, out_node_addr, out_parent_addr, out_layer,
    output ready
  );
endinterface

// ===== design/mnt_cell.sv =====
module mnt_cell import mnt_pkg::*; (
  input  logic             clk,
  input  logic [CNT_W-1:0] my_index,
  input  cell_cmd_t        cmd,
  input  cell_data_t       nbr,
  input  cell_data_t       rd_in,
  input  logic             hit_in,
  output logic             hit_out,
  output logic             changed,
  output cell_data_t       data_out,
  output cell_data_t       rd_out
);

  cell_data_t data;
  cell_data_t rd;
  logic       valid;
  logic       hit;
  logic       prefix;
  logic       sel;

  // Compare own entry against the broadcast key
  assign valid   = (my_index < cmd.count);
  assign hit     = valid && (data.key == cmd.key);
  assign changed = hit && ((data.parent != cmd.parent) || (data.layer != cmd.layer));
  assign prefix  = hit_in || hit;
  assign hit_out = prefix;
  assign sel     = (CMP_W'(my_index) == CMP_W'(cmd.read_index));

  assign data_out = data;
  assign rd_out   = rd;

  // Rewrite, append, close the gap, or pass the read word down the row
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_WRITE: begin
        if (hit) begin
          data.parent <= cmd.parent;
          data.layer  <= cmd.layer;
        end
      end
      OP_APPEND: begin
        if (my_index == cmd.count) begin
          data.key    <= cmd.key;
          data.parent <= cmd.parent;
          data.layer  <= cmd.layer;
        end
      end
      OP_SHIFT: begin
        if (prefix) begin
          data <= nbr;
        end
      end
      OP_READ: begin
        rd <= sel ? data : rd_in;
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/mnt_row.sv =====
module mnt_row import mnt_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  output row_stat_t stat
);

  cell_data_t            data_w [TABLE_SIZE];
  cell_data_t            rd_w   [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] changed_w;
  logic [TABLE_SIZE:0]   chain_w;

  assign chain_w[0] = 1'b0;

  // Row of cells, each linked to the one above it
  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    cell_data_t nbr_w;
    cell_data_t rd_in_w;

    if (i == TABLE_SIZE - 1) begin : g_last
      assign nbr_w   = data_w[i];
      assign rd_in_w = data_w[i];
    end else begin : g_mid
      assign nbr_w   = data_w[i+1];
      assign rd_in_w = rd_w[i+1];
    end

    mnt_cell u_cell (
      .clk      (clk),
      .my_index (CNT_W'(i)),
      .cmd      (cmd),
      .nbr      (nbr_w),
      .rd_in    (rd_in_w),
      .hit_in   (chain_w[i]),
      .hit_out  (chain_w[i+1]),
      .changed  (changed_w[i]),
      .data_out (data_w[i]),
      .rd_out   (rd_w[i])
    );
  end

  // Collect row status
  assign stat.any_hit     = chain_w[TABLE_SIZE];
  assign stat.any_changed = |changed_w;
  assign stat.rd          = rd_w[0];

endmodule

// ===== design/mesh_node_table.sv =====
// Channel | Dir | Words                                          | Handshake
// req     | in  | func, node_addr, parent_addr, layer, read_index | valid/ready
// rsp     | out | status, entry_count, out_node_addr,             | valid/ready
//         |     | out_parent_addr, out_layer                      |
//
// Update, clear, insert and a read past the count go straight from execute
// to finish; remove does one cell-row shift per removed entry first; a read
// within the count passes through the read state while the read word walks
// down the cell row to cell 0.
// Reset clears count and control state; cells are ignored until written.
// A finished result waits in the output register; the next word is taken
// while it waits, and its result holds until the output register frees up.
module mesh_node_table import mnt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mnt_in_if.sink    req,
  mnt_out_if.source rsp
);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               removed;
  logic               removed_next;
  logic [IDX_W-1:0]   rd_cnt;
  logic [IDX_W-1:0]   rd_cnt_next;

  func_t              it_func;
  logic [ADDR_W-1:0]  it_key;
  logic [ADDR_W-1:0]  it_par;
  logic [LAYER_W-1:0] it_lay;
  logic [RIDX_W-1:0]  it_idx;

  status_t            res_status;
  status_t            res_status_next;
  cell_data_t         res_data;

  logic               out_valid;
  status_t            out_status;
  logic [ECNT_W-1:0]  out_count;
  cell_data_t         out_data;

  logic               accept;
  logic               capture;
  logic               load_out;
  logic               idx_ok;
  logic               full;
  cell_cmd_t          cmd;
  row_stat_t          stat;

  assign accept = req.valid && req.ready;
  assign idx_ok = (CMP_W'(it_idx) < CMP_W'(count));
  assign full   = (count == CNT_W'(TABLE_SIZE));

  // Cell row
  mnt_row u_row (
    .clk  (clk),
    .cmd  (cmd),
    .stat (stat)
  );

  // Next state and cell commands
  always_comb begin
    state_next      = state;
    count_next      = count;
    removed_next    = removed;
    rd_cnt_next     = rd_cnt;
    res_status_next = res_status;
    capture         = 1'b0;
    load_out        = 1'b0;
    req.ready       = 1'b0;

    cmd.op         = OP_HOLD;
    cmd.key        = it_key;
    cmd.parent     = it_par;
    cmd.layer      = it_lay;
    cmd.count      = count;
    cmd.read_index = it_idx;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          removed_next = 1'b0;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (it_func)
          FN_UPDATE: begin
            state_next = S_FINISH;
            if (stat.any_hit) begin
              cmd.op          = OP_WRITE;
              res_status_next = stat.any_changed ? ST_UPDATED : ST_UNCHANGED;
            end else if (full) begin
              res_status_next = ST_FULL;
            end else begin
              cmd.op          = OP_APPEND;
              count_next      = count + CNT_W'(1);
              res_status_next = ST_INSERTED;
            end
          end
          FN_REMOVE: begin
            // Drop the lowest match each cycle until none is left
            if (stat.any_hit) begin
              cmd.op       = OP_SHIFT;
              count_next   = count - CNT_W'(1);
              removed_next = 1'b1;
            end else begin
              res_status_next = removed ? ST_REMOVED : ST_NOT_FOUND;
              state_next      = S_FINISH;
            end
          end
          FN_CLEAR: begin
            count_next      = '0;
            res_status_next = ST_CLEARED;
            state_next      = S_FINISH;
          end
          FN_READ: begin
            if (idx_ok) begin
              cmd.op      = OP_READ;
              rd_cnt_next = '0;
              state_next  = S_READ;
            end else begin
              res_status_next = ST_BAD_INDEX;
              state_next      = S_FINISH;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_READ: begin
        cmd.op = OP_READ;
        if (rd_cnt == IDX_W'(TABLE_SIZE - 1)) begin
          capture         = 1'b1;
          res_status_next = ST_READ_OK;
          state_next      = S_FINISH;
        end else begin
          rd_cnt_next = rd_cnt + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      removed   <= 1'b0;
      rd_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      removed <= removed_next;
      rd_cnt  <= rd_cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the incoming word and build the result
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    if (accept) begin
      it_func  <= func_t'(req.func);
      it_key   <= req.node_addr;
      it_par   <= req.parent_addr;
      it_lay   <= req.layer;
      it_idx   <= req.read_index;
      res_data <= '0;
    end else if (capture) begin
      res_data <= stat.rd;
    end
  end

  // Output register, count saturated to the result width
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= res_status;
      out_data   <= res_data;
      if (32'(count) > 32'(COUNT_MAX)) begin
        out_count <= ECNT_W'(COUNT_MAX);
      end else begin
        out_count <= ECNT_W'(count);
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.entry_count     = out_count;
  assign rsp.out_node_addr   = out_data.key;
  assign rsp.out_parent_addr = out_data.parent;
  assign rsp.out_layer       = out_data.layer;

endmodule
